// File: src/uvs_pkg.sv
// Shared types, constants and helper functions for the UV sphere vertex generator.
// Holds the transaction structs, the CORDIC arctangent table, and the rounding helpers.
// Has no dependencies.
package uvs_pkg;

  localparam int INDEX_BITS = 10;
  localparam int FRAC_BITS  = 14;
  localparam int SIGNED_W   = FRAC_BITS + 2;
  localparam int TEX_W      = FRAC_BITS + 1;

  // Long division yields a 33-bit quotient for every lane.
  localparam int DIV_STEPS = 33;
  localparam int NUM_W     = INDEX_BITS + DIV_STEPS;

  // CORDIC datapath: Q1.30 with headroom.
  localparam int CORE_W = 34;
  localparam logic signed [CORE_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [0:0] REG_RING_COUNT    = 1'b0;
  localparam logic [0:0] REG_SEGMENT_COUNT = 1'b1;

  localparam logic [INDEX_BITS-1:0] RING_COUNT_RESET    = INDEX_BITS'(16);
  localparam logic [INDEX_BITS-1:0] SEGMENT_COUNT_RESET = INDEX_BITS'(32);
  localparam logic [INDEX_BITS-1:0] COUNT_MIN           = INDEX_BITS'(3);

  localparam logic [TEX_W-1:0] TEX_ONE = TEX_W'(1) << FRAC_BITS;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic [INDEX_BITS-1:0] ring_index;
    logic [INDEX_BITS-1:0] segment_index;
  } grid_t;

  typedef struct packed {
    logic signed [SIGNED_W-1:0] pos_x;
    logic signed [SIGNED_W-1:0] pos_y;
    logic signed [SIGNED_W-1:0] pos_z;
    logic signed [SIGNED_W-1:0] norm_x;
    logic signed [SIGNED_W-1:0] norm_y;
    logic signed [SIGNED_W-1:0] norm_z;
    logic [TEX_W-1:0]           tex_u;
    logic [TEX_W-1:0]           tex_v;
    logic signed [SIGNED_W-1:0] tan_x;
    logic signed [SIGNED_W-1:0] tan_z;
    logic                       index_error;
  } vertex_t;

  typedef struct packed {
    logic signed [CORE_W-1:0] x;
    logic signed [CORE_W-1:0] y;
    logic signed [CORE_W-1:0] z;
    logic                     flip;
  } rot_t;

  function automatic logic [INDEX_BITS-1:0] clamp_count(input logic [INDEX_BITS-1:0] v);
    return (v < COUNT_MIN) ? COUNT_MIN : v;
  endfunction

  // Fold a turn fraction into +/- a quarter turn; flip marks a half-turn offset.
  function automatic rot_t fold_turn(input logic [31:0] word);
    rot_t                     r;
    logic signed [CORE_W-1:0] a;
    a      = CORE_W'(signed'(word));
    r.x    = CORDIC_GAIN;
    r.y    = '0;
    r.z    = a;
    r.flip = 1'b0;
    if (a > (34'sd1 <<< 30)) begin
      r.z    = a - (34'sd1 <<< 31);
      r.flip = 1'b1;
    end else if (a < -(34'sd1 <<< 30)) begin
      r.z    = a + (34'sd1 <<< 31);
      r.flip = 1'b1;
    end
    return r;
  endfunction

  // Round half up by sh bits, then saturate to +/- one.
  function automatic logic signed [SIGNED_W-1:0] round_sat(input logic signed [64:0] v,
                                                           input int sh);
    logic signed [64:0] t;
    t = (v + (65'sd1 <<< (sh - 1))) >>> sh;
    if (t > (65'sd1 <<< FRAC_BITS)) begin
      t = 65'sd1 <<< FRAC_BITS;
    end else if (t < -(65'sd1 <<< FRAC_BITS)) begin
      t = -(65'sd1 <<< FRAC_BITS);
    end
    return signed'(t[SIGNED_W-1:0]);
  endfunction

endpackage

// File: src/uv_sphere_vertex_generator.sv
// Top level of the UV sphere vertex generator.
// Depends on uvs_pkg, uvs_div_cell and uvs_cordic_cell.
//
// Usage
//   grid channel (grid_valid/grid_ready/grid) carries one grid point per
//   transaction; vert channel (vert_valid/vert_ready/vert) returns one vertex
//   per transaction, in order. cfg_write with cfg_index/cfg_data sets the
//   ring and segment counts; write only while no transaction is in flight.
//   Counts below three are stored as three.
// Pipeline and throughput
//   A vertex appears on vert after passing one input register, 33 long-division
//   cells, CORDIC_STAGES rotation cells, one multiply stage and the output
//   register. One transaction per cycle is sustained while vert is not
//   stalled; the division and rotation chains hand data cell to cell every
//   cycle in which the chain advances.
// Reset
//   rst (synchronous) empties the chain and the output buffer and restores
//   16 rings and 32 segments.
// Stalls
//   While vert is held, the chain keeps moving until one more result has
//   landed in a skid register; then grid_ready drops and the whole chain
//   holds until the output register is drained.
module uv_sphere_vertex_generator #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             grid_valid,
  output logic                             grid_ready,
  input  uvs_pkg::grid_t                   grid,
  output logic                             vert_valid,
  input  logic                             vert_ready,
  output uvs_pkg::vertex_t                 vert,
  input  logic                             cfg_write,
  input  logic [0:0]                       cfg_index,
  input  logic [uvs_pkg::INDEX_BITS-1:0]   cfg_data
);

  localparam int IB   = uvs_pkg::INDEX_BITS;
  localparam int FB   = uvs_pkg::FRAC_BITS;
  localparam int NW   = uvs_pkg::NUM_W;
  localparam int DS   = uvs_pkg::DIV_STEPS;
  localparam int CW   = uvs_pkg::CORE_W;
  localparam int LAST = DS + CORDIC_STAGES + 1;

  // Lane order: latitude angle, longitude angle, texture u, texture v.
  localparam int LANES = 4;

  // ---------------------------------------------------------------- config
  logic [IB-1:0] ring_count;
  logic [IB-1:0] segment_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count    <= uvs_pkg::RING_COUNT_RESET;
      segment_count <= uvs_pkg::SEGMENT_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        uvs_pkg::REG_RING_COUNT:    ring_count    <= uvs_pkg::clamp_count(cfg_data);
        uvs_pkg::REG_SEGMENT_COUNT: segment_count <= uvs_pkg::clamp_count(cfg_data);
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- flow control
  logic adv;
  logic skid_full;
  logic pop;
  logic arrive;

  // The chain advances as a whole whenever the skid register is free.
  assign adv        = !skid_full;
  assign grid_ready = adv;

  // Valid and error flags ride alongside the data, one slot per stage.
  logic            vld [0:LAST];
  logic            err [0:LAST];
  logic [IB-1:0]   p_ring;
  logic [IB-1:0]   p_seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LAST; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= grid_valid;
      for (int i = 1; i <= LAST; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ring <= grid.ring_index;
      p_seg  <= grid.segment_index;
      err[0] <= (grid.ring_index > ring_count) || (grid.segment_index > segment_count);
      for (int i = 1; i <= LAST; i++) begin
        err[i] <= err[i-1];
      end
    end
  end

  // ------------------------------------------------------ division chain
  // Each lane computes floor((index * 2^shift + count/2) / count).
  logic [NW-1:0] dw [LANES][DS+1];

  assign dw[0][0] = (NW'(p_ring) << 31) + NW'(ring_count >> 1);
  assign dw[1][0] = (NW'(p_seg) << 32) + NW'(segment_count >> 1);
  assign dw[2][0] = (NW'(p_seg) << FB) + NW'(segment_count >> 1);
  assign dw[3][0] = (NW'(p_ring) << FB) + NW'(ring_count >> 1);

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    for (genvar k = 0; k < DS; k++) begin : g_div
      uvs_div_cell u_cell (
        .clk  (clk),
        .en   (adv),
        .den  ((l == 0 || l == 3) ? ring_count : segment_count),
        .w_in (dw[l][k]),
        .w    (dw[l][k+1])
      );
    end
  end

  // -------------------------------------------------------- CORDIC chains
  uvs_pkg::rot_t rl [0:CORDIC_STAGES];
  uvs_pkg::rot_t rs [0:CORDIC_STAGES];

  // Longitude word wraps modulo a full turn, so the seam column folds to zero.
  assign rl[0] = uvs_pkg::fold_turn(dw[0][DS][31:0]);
  assign rs[0] = uvs_pkg::fold_turn(dw[1][DS][31:0]);

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_rot
    uvs_cordic_cell #(.STAGE(j)) u_lat (
      .clk   (clk),
      .en    (adv),
      .r_in  (rl[j]),
      .r_out (rl[j+1])
    );
    uvs_cordic_cell #(.STAGE(j)) u_lon (
      .clk   (clk),
      .en    (adv),
      .r_in  (rs[j]),
      .r_out (rs[j+1])
    );
  end

  // Texture coordinates wait alongside the rotation cells.
  logic [uvs_pkg::TEX_W-1:0] tu [1:CORDIC_STAGES];
  logic [uvs_pkg::TEX_W-1:0] tv [1:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (adv) begin
      tu[1] <= dw[2][DS][uvs_pkg::TEX_W-1:0];
      tv[1] <= dw[3][DS][uvs_pkg::TEX_W-1:0];
      for (int i = 2; i <= CORDIC_STAGES; i++) begin
        tu[i] <= tu[i-1];
        tv[i] <= tv[i-1];
      end
    end
  end

  // -------------------------------------------------------- multiply stage
  logic signed [CW-1:0] sl;
  logic signed [CW-1:0] cl;
  logic signed [CW-1:0] ss;
  logic signed [CW-1:0] cs;
  logic signed [31:0]   sl32;
  logic signed [31:0]   ss32;
  logic signed [31:0]   cs32;
  logic signed [63:0]   prod_s;
  logic signed [63:0]   prod_c;

  // Undo the half-turn fold by negating both sine and cosine.
  assign sl = rl[CORDIC_STAGES].flip ? -rl[CORDIC_STAGES].y : rl[CORDIC_STAGES].y;
  assign cl = rl[CORDIC_STAGES].flip ? -rl[CORDIC_STAGES].x : rl[CORDIC_STAGES].x;
  assign ss = rs[CORDIC_STAGES].flip ? -rs[CORDIC_STAGES].y : rs[CORDIC_STAGES].y;
  assign cs = rs[CORDIC_STAGES].flip ? -rs[CORDIC_STAGES].x : rs[CORDIC_STAGES].x;

  // Results stay within about one in Q1.30, so 32 bits carry them exactly.
  assign sl32   = sl[31:0];
  assign ss32   = ss[31:0];
  assign cs32   = cs[31:0];
  assign prod_s = sl32 * ss32;
  assign prod_c = sl32 * cs32;

  logic signed [63:0]        m_ps;
  logic signed [63:0]        m_pc;
  logic signed [CW-1:0]      m_cl;
  logic signed [CW-1:0]      m_cs;
  logic signed [CW-1:0]      m_ss;
  logic [uvs_pkg::TEX_W-1:0] m_tu;
  logic [uvs_pkg::TEX_W-1:0] m_tv;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_ps <= prod_s;
      m_pc <= prod_c;
      m_cl <= cl;
      m_cs <= cs;
      m_ss <= ss;
      m_tu <= tu[CORDIC_STAGES];
      m_tv <= tv[CORDIC_STAGES];
    end
  end

  // -------------------------------------------------------- round and pack
  uvs_pkg::vertex_t res;

  always_comb begin
    res = '0;
    if (err[LAST]) begin
      res.index_error = 1'b1;
    end else begin
      res.pos_x  = uvs_pkg::round_sat(65'(m_ps), 61 - FB);
      res.pos_y  = uvs_pkg::round_sat(65'(m_cl), 31 - FB);
      res.pos_z  = uvs_pkg::round_sat(65'(m_pc), 61 - FB);
      res.norm_x = uvs_pkg::round_sat(65'(m_ps), 60 - FB);
      res.norm_y = uvs_pkg::round_sat(65'(m_cl), 30 - FB);
      res.norm_z = uvs_pkg::round_sat(65'(m_pc), 60 - FB);
      res.tex_u  = m_tu;
      res.tex_v  = m_tv;
      res.tan_x  = uvs_pkg::round_sat(65'(m_cs), 30 - FB);
      res.tan_z  = uvs_pkg::round_sat(-65'(m_ss), 30 - FB);
    end
  end

  // -------------------------------------------------- output and skid
  uvs_pkg::vertex_t skid;

  assign pop    = vert_valid && vert_ready;
  assign arrive = adv && vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vert_valid <= 1'b0;
      skid_full  <= 1'b0;
    end else if (skid_full) begin
      // Drain the skid into the output register once the receiver takes one.
      if (pop) begin
        skid_full <= 1'b0;
      end
    end else if (!vert_valid || pop) begin
      vert_valid <= arrive;
    end else if (arrive) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (pop) begin
        vert <= skid;
      end
    end else if (!vert_valid || pop) begin
      if (arrive) begin
        vert <= res;
      end
    end else if (arrive) begin
      skid <= res;
    end
  end

  // ---------------------------------------------------------- assertions
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_full |-> vert_valid)
    else $error("skid holds a result while the output register is empty");

  a_ready_tracks_skid : assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(vert_valid) && !$past(vert_ready))
    else $error("skid filled without an output stall");

  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !vert_valid && !skid_full)
    else $error("output not empty after reset");

  a_error_zeroes : assert property (@(posedge clk) disable iff (rst)
    vert_valid && vert.index_error |->
      vert.pos_x == '0 && vert.norm_y == '0 && vert.tex_u == '0 && vert.tan_z == '0)
    else $error("error vertex carries non-zero fields");

  a_tex_range : assert property (@(posedge clk) disable iff (rst)
    vert_valid && !vert.index_error |->
      vert.tex_u <= uvs_pkg::TEX_ONE && vert.tex_v <= uvs_pkg::TEX_ONE)
    else $error("texture coordinate beyond one");

endmodule

// File: src/uvs_div_cell.sv
// One restoring-division step: one quotient bit per cell.
// Depends on uvs_pkg for widths.
module uvs_div_cell (
  input  logic                             clk,
  input  logic                             en,
  input  logic [uvs_pkg::INDEX_BITS-1:0]   den,
  input  logic [uvs_pkg::NUM_W-1:0]        w_in,
  output logic [uvs_pkg::NUM_W-1:0]        w
);

  localparam int IB = uvs_pkg::INDEX_BITS;
  localparam int DS = uvs_pkg::DIV_STEPS;

  logic [IB:0]                 cand;
  logic [IB:0]                 diff;
  logic                        ge;
  logic [IB-1:0]               rem_next;
  logic [uvs_pkg::NUM_W-1:0]   w_next;

  // Partial remainder sits on top, pending dividend bits below, quotient enters at the bottom.
  assign cand     = w_in[uvs_pkg::NUM_W-1:DS-1];
  assign diff     = cand - {1'b0, den};
  assign ge       = (cand >= {1'b0, den});
  assign rem_next = ge ? diff[IB-1:0] : cand[IB-1:0];
  assign w_next   = {rem_next, w_in[DS-2:0], ge};

  always_ff @(posedge clk) begin
    if (en) begin
      w <= w_next;
    end
  end

endmodule

// File: src/uvs_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation with its own arctangent constant.
// Depends on uvs_pkg for the rotation struct and the arctangent table.
module uvs_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          en,
  input  uvs_pkg::rot_t r_in,
  output uvs_pkg::rot_t r_out
);

  localparam int CW = uvs_pkg::CORE_W;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] at;
  uvs_pkg::rot_t        r_next;

  assign dx = r_in.y >>> STAGE;
  assign dy = r_in.x >>> STAGE;
  assign at = signed'({2'b00, uvs_pkg::ATAN_TURNS[STAGE]});

  always_comb begin
    r_next.flip = r_in.flip;
    if (!r_in.z[CW-1]) begin
      r_next.x = r_in.x - dx;
      r_next.y = r_in.y + dy;
      r_next.z = r_in.z - at;
    end else begin
      r_next.x = r_in.x + dx;
      r_next.y = r_in.y - dy;
      r_next.z = r_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_out <= r_next;
    end
  end

endmodule

// File: tb/tb_uv_sphere_vertex_generator.sv
// Self-checking testbench for the UV sphere vertex generator.
// Depends on uvs_pkg and uv_sphere_vertex_generator; predicts each vertex in-house.
// Runs directed grid points then random ones across count settings and idle patterns.
module tb_uv_sphere_vertex_generator;

  localparam int STAGES     = 16;
  localparam int LATENCY    = 35 + STAGES;
  localparam int DRAIN_WAIT = LATENCY + 20;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD  = 400;

  logic    clk;
  logic    rst;
  logic    grid_valid;
  logic    grid_ready;
  uvs_pkg::grid_t   grid;
  logic    vert_valid;
  logic    vert_ready;
  uvs_pkg::vertex_t vert;
  logic    cfg_write;
  logic [0:0] cfg_index;
  logic [uvs_pkg::INDEX_BITS-1:0] cfg_data;

  uv_sphere_vertex_generator #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst(rst),
    .grid_valid(grid_valid), .grid_ready(grid_ready), .grid(grid),
    .vert_valid(vert_valid), .vert_ready(vert_ready), .vert(vert),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copies of the two count registers, as the block should hold them
  logic [uvs_pkg::INDEX_BITS-1:0] rings_now;
  logic [uvs_pkg::INDEX_BITS-1:0] segments_now;

  uvs_pkg::grid_t   points_to_send[$];
  uvs_pkg::vertex_t vertices_due[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;     // cycles of long receiver hold wanted; set once
  int hold_done;        // counted by the monitor
  int mismatches;
  int points_sent;
  int vertices_seen;
  int error_vertices;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Signed Q2.14 rounding (half up) with saturation to +/- one
  function automatic logic [uvs_pkg::SIGNED_W-1:0] round_unit(input longint v, input int sh);
    longint t;
    t = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    if (t > (longint'(1) <<< uvs_pkg::FRAC_BITS)) t = longint'(1) <<< uvs_pkg::FRAC_BITS;
    if (t < -(longint'(1) <<< uvs_pkg::FRAC_BITS)) t = -(longint'(1) <<< uvs_pkg::FRAC_BITS);
    return t[uvs_pkg::SIGNED_W-1:0];
  endfunction

  // Rotation-mode CORDIC on a turn fraction; results in Q1.30
  function automatic void turn_sin_cos(input logic [31:0] word, output longint s_q30,
                                       output longint c_q30);
    longint a, x, y, z, dx, dy;
    bit flip;
    a = longint'(signed'(word));
    flip = 1'b0;
    // fold to within a quarter turn, negate both at the end
    if (a > (longint'(1) <<< 30)) begin
      a = a - (longint'(1) <<< 31);
      flip = 1'b1;
    end else if (a < -(longint'(1) <<< 30)) begin
      a = a + (longint'(1) <<< 31);
      flip = 1'b1;
    end
    x = longint'(uvs_pkg::CORDIC_GAIN);
    y = 0;
    z = a;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(uvs_pkg::ATAN_TURNS[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(uvs_pkg::ATAN_TURNS[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s_q30 = y;
    c_q30 = x;
  endfunction

  function automatic uvs_pkg::vertex_t sphere_vertex(input uvs_pkg::grid_t p);
    uvs_pkg::vertex_t v;
    longint  r, s, rc, sc, sl, cl, ss, cs;
    logic [63:0] lat_w, lon_w;
    v  = '0;
    r  = p.ring_index;
    s  = p.segment_index;
    rc = rings_now;
    sc = segments_now;
    if (r > rc || s > sc) begin
      v.index_error = 1'b1;
      return v;
    end
    lat_w = ((r <<< 31) + rc / 2) / rc;
    lon_w = ((s <<< 32) + sc / 2) / sc;
    turn_sin_cos(lat_w[31:0], sl, cl);
    turn_sin_cos(lon_w[31:0], ss, cs);
    v.pos_x  = round_unit(sl * ss, 60 - uvs_pkg::FRAC_BITS + 1);
    v.pos_y  = round_unit(cl, 30 - uvs_pkg::FRAC_BITS + 1);
    v.pos_z  = round_unit(sl * cs, 60 - uvs_pkg::FRAC_BITS + 1);
    v.norm_x = round_unit(sl * ss, 60 - uvs_pkg::FRAC_BITS);
    v.norm_y = round_unit(cl, 30 - uvs_pkg::FRAC_BITS);
    v.norm_z = round_unit(sl * cs, 60 - uvs_pkg::FRAC_BITS);
    v.tex_u  = uvs_pkg::TEX_W'(((s <<< uvs_pkg::FRAC_BITS) + sc / 2) / sc);
    v.tex_v  = uvs_pkg::TEX_W'(((r <<< uvs_pkg::FRAC_BITS) + rc / 2) / rc);
    v.tan_x  = round_unit(cs, 30 - uvs_pkg::FRAC_BITS);
    v.tan_z  = round_unit(-ss, 30 - uvs_pkg::FRAC_BITS);
    return v;
  endfunction

  // Driver: advance to the next pending point once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      grid_valid <= 1'b0;
      grid       <= '0;
    end else begin
      if (grid_valid && grid_ready) begin
        vertices_due = {vertices_due, sphere_vertex(grid)};
        points_sent++;
      end
      if (!grid_valid || grid_ready) begin
        if (points_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          grid       <= points_to_send.pop_front();
          grid_valid <= 1'b1;
        end else begin
          grid_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every accepted vertex against the oldest prediction
  always @(posedge clk) begin
    uvs_pkg::vertex_t want;
    if (rst) begin
      vert_ready <= 1'b0;
    end else begin
      if (vert_valid && vert_ready) begin
        vertices_seen++;
        if (vert.index_error) error_vertices++;
        if (vertices_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected vertex, exp none got %h", $time, vert);
        end else begin
          want = vertices_due.pop_front();
          if (vert.pos_x !== want.pos_x)
            $display("%0t: pos_x exp %0d got %0d", $time, want.pos_x, vert.pos_x);
          if (vert.pos_y !== want.pos_y)
            $display("%0t: pos_y exp %0d got %0d", $time, want.pos_y, vert.pos_y);
          if (vert.pos_z !== want.pos_z)
            $display("%0t: pos_z exp %0d got %0d", $time, want.pos_z, vert.pos_z);
          if (vert.norm_x !== want.norm_x)
            $display("%0t: norm_x exp %0d got %0d", $time, want.norm_x, vert.norm_x);
          if (vert.norm_y !== want.norm_y)
            $display("%0t: norm_y exp %0d got %0d", $time, want.norm_y, vert.norm_y);
          if (vert.norm_z !== want.norm_z)
            $display("%0t: norm_z exp %0d got %0d", $time, want.norm_z, vert.norm_z);
          if (vert.tex_u !== want.tex_u)
            $display("%0t: tex_u exp %0d got %0d", $time, want.tex_u, vert.tex_u);
          if (vert.tex_v !== want.tex_v)
            $display("%0t: tex_v exp %0d got %0d", $time, want.tex_v, vert.tex_v);
          if (vert.tan_x !== want.tan_x)
            $display("%0t: tan_x exp %0d got %0d", $time, want.tan_x, vert.tan_x);
          if (vert.tan_z !== want.tan_z)
            $display("%0t: tan_z exp %0d got %0d", $time, want.tan_z, vert.tan_z);
          if (vert.index_error !== want.index_error)
            $display("%0t: index_error exp %0b got %0b", $time, want.index_error,
                     vert.index_error);
          if (vert !== want) mismatches++;
        end
      end
      // a requested long hold takes priority over random stalls
      if (hold_done < hold_request) begin
        hold_done++;
        vert_ready <= 1'b0;
      end else begin
        vert_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves on either side
  always @(posedge clk) begin
    if (rst || (grid_valid && grid_ready) || (vert_valid && vert_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("uv_sphere_vertex_generator regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_count(input logic [0:0] idx, input int value);
    logic [uvs_pkg::INDEX_BITS-1:0] v;
    v = uvs_pkg::INDEX_BITS'(value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == uvs_pkg::REG_RING_COUNT) rings_now = (v < 3) ? uvs_pkg::INDEX_BITS'(3) : v;
    else segments_now = (v < 3) ? uvs_pkg::INDEX_BITS'(3) : v;
  endtask

  task automatic queue_point(input int r, input int s);
    uvs_pkg::grid_t p;
    p.ring_index    = uvs_pkg::INDEX_BITS'(r);
    p.segment_index = uvs_pkg::INDEX_BITS'(s);
    points_to_send = {points_to_send, p};
  endtask

  // Mostly in-range points (edges and one past the edge included), the rest any 10-bit value
  task automatic queue_random(input int n);
    int r_hi, s_hi;
    r_hi = (rings_now + 1 > 1023) ? 1023 : rings_now + 1;
    s_hi = (segments_now + 1 > 1023) ? 1023 : segments_now + 1;
    repeat (n) begin
      if ($urandom_range(9) < 8) queue_point($urandom_range(r_hi), $urandom_range(s_hi));
      else queue_point($urandom_range(1023), $urandom_range(1023));
    end
  endtask

  // Hold until everything sent has come back, then let the pipe settle
  task automatic drain;
    while (points_to_send.size() > 0 || grid_valid || vertices_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_idling(input int snd, input int rcv);
    @(negedge clk);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = uvs_pkg::REG_RING_COUNT;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 0;
    hold_done = 0;
    mismatches = 0;
    points_sent = 0;
    vertices_seen = 0;
    error_vertices = 0;
    rings_now = uvs_pkg::RING_COUNT_RESET;
    segments_now = uvs_pkg::SEGMENT_COUNT_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset counts, poles, seam, equator, one past and far past
    queue_point(0, 0);
    queue_point(16, 32);
    queue_point(8, 8);
    queue_point(8, 16);
    queue_point(8, 24);
    queue_point(4, 0);
    queue_point(12, 31);
    queue_point(17, 0);
    queue_point(0, 33);
    queue_point(17, 33);
    queue_point(1023, 1023);
    queue_point(16, 0);
    queue_point(0, 32);
    queue_point(682, 341);
    drain();

    // Counts written below three clamp to three
    write_count(uvs_pkg::REG_RING_COUNT, 0);
    write_count(uvs_pkg::REG_SEGMENT_COUNT, 1);
    for (int r = 0; r <= 4; r++)
      for (int s = 0; s <= 4; s += 2) queue_point(r, s);
    queue_random(100);
    drain();

    // Largest counts, streaming flat out
    write_count(uvs_pkg::REG_RING_COUNT, 1023);
    write_count(uvs_pkg::REG_SEGMENT_COUNT, 1023);
    queue_point(1023, 1023);
    queue_point(0, 1023);
    queue_point(511, 256);
    queue_random(150);
    drain();

    // Mixed counts under the four idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      write_count(uvs_pkg::REG_RING_COUNT, $urandom_range(3, 1023));
      write_count(uvs_pkg::REG_SEGMENT_COUNT, (ph == 1) ? 2 : $urandom_range(3, 64));
      case (ph)
        0: set_idling(74, 0);
        1: set_idling(0, 74);
        2: set_idling(11, 11);
        default: set_idling(0, 0);
      endcase
      // long receiver hold while the sender keeps offering: fills the pipe
      if (ph == 3) hold_request = LONG_HOLD;
      queue_random(150);
      drain();
    end

    write_count(uvs_pkg::REG_RING_COUNT, 16);
    write_count(uvs_pkg::REG_SEGMENT_COUNT, 1023);
    set_idling(11, 11);
    queue_random(60);
    drain();

    if (vertices_due.size() > 0) mismatches += vertices_due.size();
    $display("Covered %0d grid points (%0d out of range) over clamped, maximal and mixed counts,",
             points_sent, error_vertices);
    $display("with idle/stall patterns and one long output hold; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("uv_sphere_vertex_generator regression: pass");
    end else begin
      $display("uv_sphere_vertex_generator regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
src/uvs_pkg.sv
src/uvs_div_cell.sv
src/uvs_cordic_cell.sv
src/uv_sphere_vertex_generator.sv
tb/tb_uv_sphere_vertex_generator.sv
